FILE: hdl/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package bsfr_pkg;

  // Frame framing bytes
  localparam logic [7:0] SYNC1_BYTE = 8'hAA;
  localparam logic [7:0] SYNC2_BYTE = 8'hBB;
  localparam logic [7:0] ESC_BYTE   = 8'hAA;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] HDR_LEN    = 8'd6;

  // Configuration register reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  MAX_LEN_RST = 8'd64;

  // Configuration register indexes
  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_MAX_LEN = 1'b1
  } cfg_idx_t;

  // Command field codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_SYNC     = 3'd0;
  localparam logic [2:0] ERR_ESCAPE   = 3'd1;
  localparam logic [2:0] ERR_RESERVED = 3'd2;
  localparam logic [2:0] ERR_LENGTH   = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM = 3'd4;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd5;

  // Parser phases
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_LEN     = 4'd2,
    PH_ZERO    = 4'd3,
    PH_ID_HI   = 4'd4,
    PH_ID_LO   = 4'd5,
    PH_CMD_HI  = 4'd6,
    PH_CMD_LO  = 4'd7,
    PH_STATUS  = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_CHECK   = 4'd10
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] frame_id;
    logic [15:0] frame_cmd;
    logic [7:0]  frame_status;
    logic [7:0]  payload_len;
    logic [2:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  max_payload_len;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/byte_stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: one input register, single-pass parser and a
// result register holding at most one result per request. A new request is
// taken every cycle unless the input side stalls; its result is presented
// once the parser has run on the input register and loaded the result
// register. The input side stalls only while a result is held by a stalled
// output and the request waiting in the input register would produce another
// one. Ticks count only inside a frame; configuration applies at its next use.
// Depends on bsfr_pkg, bsfr_cfg_regs and bsfr_parser.
`default_nettype none

module byte_stuffed_frame_receiver import bsfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cfg_t      cfg;
  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r;
  logic      res_vld;
  out_item_t res;
  logic      fire;
  logic      load_out;

  bsfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (in_item_r),
    .cfg     (cfg),
    .res_vld (res_vld),
    .res     (res)
  );

  // Process the held request unless its result has nowhere to go
  assign fire     = in_vld_r && (!res_vld || !out_vld_r || !out_stall);
  assign load_out = fire && res_vld;
  assign in_stall = in_vld_r && !fire;

  // Input register occupancy and result register occupancy
  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    if (in_valid && !in_stall) in_vld_nxt = 1'b1;
    else if (fire)             in_vld_nxt = 1'b0;
    if (load_out)                   out_vld_nxt = 1'b1;
    else if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold payloads
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_data;
    if (load_out)              out_item_r <= res;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  // A produced result is always presented the next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_vld_r)
    else $error("result lost between parser and output register");

  // A request that could not be processed stays in the input register
  a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !fire) |=> (in_vld_r && $stable(in_item_r)))
    else $error("unprocessed request dropped or overwritten");

  // Stall is raised only with a request held
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

endmodule

`default_nettype wire

FILE: hdl/bsfr_cfg_regs.sv
// Configuration registers of the frame receiver (timeout, payload limit).
// Depends on bsfr_pkg.
`default_nettype none

module bsfr_cfg_regs import bsfr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output cfg_t             cfg
);

  logic [15:0] timeout_r;
  logic [7:0]  max_len_r;

  // Take a write at the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_MAX_LEN: max_len_r <= cfg_wdata[7:0];
      endcase
    end
  end

  assign cfg.timeout_ticks   = timeout_r;
  assign cfg.max_payload_len = max_len_r;

endmodule

`default_nettype wire

FILE: hdl/bsfr_parser.sv
// Frame parser: phase machine, unstuffing, XOR check, timeout counter.
// Single pass per request; depends on bsfr_pkg.
`default_nettype none

module bsfr_parser import bsfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output logic          res_vld,
  output out_item_t     res
);

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  check_r, check_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic       is_tick;
  logic [7:0] b;
  logic       data_ok;
  logic       bad_esc;
  logic [7:0] v;
  logic [7:0] plen;
  logic       len_bad;
  logic       tick_to;
  logic [7:0] count_inc;

  // Unstuffing and shared decode
  assign is_tick   = (item.command == CMD_TICK);
  assign b         = item.rx_byte;
  assign bad_esc   = esc_r && (b != ZERO_BYTE);
  assign data_ok   = esc_r ? (b == ZERO_BYTE) : (b != ESC_BYTE);
  assign v         = esc_r ? ESC_BYTE : b;
  assign plen      = length_r - HDR_LEN;
  assign len_bad   = (length_r < HDR_LEN) || (plen > cfg.max_payload_len);
  assign tick_to   = (phase_r != PH_SYNC1) && (idle_r >= cfg.timeout_ticks);
  assign count_inc = count_r + 8'd1;

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    esc_nxt    = esc_r;
    check_nxt  = check_r;
    length_nxt = length_r;
    id_nxt     = id_r;
    cmd_nxt    = cmd_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    idle_nxt   = idle_r;
    if (is_tick) begin
      if (tick_to) begin
        phase_nxt = PH_SYNC1;
        esc_nxt   = 1'b0;
        idle_nxt  = '0;
      end else if (phase_r != PH_SYNC1) begin
        idle_nxt = idle_r + 16'd1;
      end
    end else begin
      idle_nxt = '0;
      unique case (phase_r)
        PH_SYNC1: begin
          esc_nxt = 1'b0;
          if (b == SYNC1_BYTE) begin
            check_nxt  = '0;
            length_nxt = '0;
            id_nxt     = '0;
            cmd_nxt    = '0;
            status_nxt = '0;
            count_nxt  = '0;
            phase_nxt  = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          esc_nxt   = 1'b0;
          phase_nxt = (b == SYNC2_BYTE) ? PH_LEN : PH_SYNC1;
        end
        PH_ZERO: begin
          esc_nxt   = 1'b0;
          phase_nxt = (b == ZERO_BYTE) ? PH_ID_HI : PH_SYNC1;
        end
        PH_CHECK: begin
          esc_nxt   = 1'b0;
          phase_nxt = PH_SYNC1;
        end
        PH_LEN, PH_ID_HI, PH_ID_LO, PH_CMD_HI, PH_CMD_LO, PH_STATUS,
        PH_PAYLOAD: begin
          // Hold an escape until its filler byte shows up
          esc_nxt = !esc_r && (b == ESC_BYTE);
          if (bad_esc) begin
            phase_nxt = PH_SYNC1;
          end else if (data_ok) begin
            unique case (phase_r)
              PH_LEN: begin
                length_nxt = v;
                phase_nxt  = PH_ZERO;
              end
              PH_ID_HI: begin
                id_nxt    = {v, 8'h00};
                check_nxt = check_r ^ v;
                phase_nxt = PH_ID_LO;
              end
              PH_ID_LO: begin
                id_nxt    = {id_r[15:8], v};
                check_nxt = check_r ^ v;
                phase_nxt = PH_CMD_HI;
              end
              PH_CMD_HI: begin
                cmd_nxt   = {v, 8'h00};
                check_nxt = check_r ^ v;
                phase_nxt = PH_CMD_LO;
              end
              PH_CMD_LO: begin
                cmd_nxt   = {cmd_r[15:8], v};
                check_nxt = check_r ^ v;
                phase_nxt = PH_STATUS;
              end
              PH_STATUS: begin
                status_nxt = v;
                if (len_bad) begin
                  phase_nxt = PH_SYNC1;
                end else begin
                  count_nxt = '0;
                  phase_nxt = (plen == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
              end
              default: begin
                check_nxt = check_r ^ v;
                count_nxt = count_inc;
                if (count_inc >= plen) phase_nxt = PH_CHECK;
              end
            endcase
          end
        end
        default: begin
          phase_nxt = PH_SYNC1;
        end
      endcase
    end
  end

  // Result of this request
  always_comb begin
    res_vld           = 1'b0;
    res.result_kind   = KIND_ERROR;
    res.payload_byte  = '0;
    res.payload_index = '0;
    res.frame_id      = id_nxt;
    res.frame_cmd     = cmd_nxt;
    res.frame_status  = status_nxt;
    res.payload_len   = '0;
    res.error_code    = '0;
    if (is_tick) begin
      if (tick_to) begin
        res_vld        = 1'b1;
        res.error_code = ERR_TIMEOUT;
      end
    end else begin
      unique case (phase_r)
        PH_SYNC1: begin
          res_vld        = (b != SYNC1_BYTE);
          res.error_code = ERR_SYNC;
        end
        PH_SYNC2: begin
          res_vld        = (b != SYNC2_BYTE);
          res.error_code = ERR_SYNC;
        end
        PH_ZERO: begin
          res_vld        = (b != ZERO_BYTE);
          res.error_code = ERR_RESERVED;
        end
        PH_CHECK: begin
          res_vld = 1'b1;
          if (b != check_r) begin
            res.error_code = ERR_CHECKSUM;
          end else begin
            res.result_kind = KIND_ACCEPT;
            res.payload_len = plen;
          end
        end
        PH_LEN, PH_ID_HI, PH_ID_LO, PH_CMD_HI, PH_CMD_LO: begin
          res_vld        = bad_esc;
          res.error_code = ERR_ESCAPE;
        end
        PH_STATUS: begin
          res_vld        = bad_esc || (data_ok && len_bad);
          res.error_code = bad_esc ? ERR_ESCAPE : ERR_LENGTH;
        end
        PH_PAYLOAD: begin
          res_vld = bad_esc || data_ok;
          if (bad_esc) begin
            res.error_code = ERR_ESCAPE;
          end else begin
            res.result_kind   = KIND_PAYLOAD;
            res.payload_byte  = v;
            res.payload_index = count_r;
            res.payload_len   = plen;
          end
        end
        default: begin
          res_vld = 1'b0;
        end
      endcase
    end
  end

  // Advance state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      esc_r    <= 1'b0;
      check_r  <= '0;
      length_r <= '0;
      id_r     <= '0;
      cmd_r    <= '0;
      status_r <= '0;
      count_r  <= '0;
      idle_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      check_r  <= check_nxt;
      length_r <= length_nxt;
      id_r     <= id_nxt;
      cmd_r    <= cmd_nxt;
      status_r <= status_nxt;
      count_r  <= count_nxt;
      idle_r   <= idle_nxt;
    end
  end

  // No escape can be left open once back at the frame start
  a_idle_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SYNC1) |-> !esc_r)
    else $error("escape pending while waiting for sync");

  // Payload index stays below the frame's payload length
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (count_r < plen))
    else $error("payload count past payload length");

endmodule

`default_nettype wire
